// ===== rtl/core/pip_pkg.sv =====
// shared types and constants of the point-in-polygon block
`default_nettype none

package pip_pkg;

    // width of one multiplier digit handled by a product cell
    localparam int DIGIT_BITS = 16;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_QUERY  = 2'd2
    } pip_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } pip_state_t;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
    } pip_cmd_item_t;

    typedef struct packed {
        logic is_inside;
        logic overflow;
    } pip_res_item_t;

    // control that travels with one edge down the pipeline
    typedef struct packed {
        logic vld;
        logic last;
        logic span;
        logic n1;
        logic n2;
    } pip_tok_t;

endpackage

`default_nettype wire

// ===== rtl/core/point_in_polygon_test_top.sv =====
// top level of the even-odd point-in-polygon block
//
//  channel  | signals                        | payload
//  ---------+--------------------------------+-------------------------------
//  command  | cmd_valid, cmd_ready, cmd_data | command, coord_x, coord_y
//  result   | res_valid, res_ready, res_data | is_inside, overflow
//
// clear and append complete as they are taken; a query over n vertices passes
// the edge stage and NDIG = ceil((COORD_BITS+1)/16) product cells, its pace set by
// the single read port of the vertex memory, which yields one vertex a cycle.
// an empty table skips the memory reads and goes straight to the done state.
// reset clears the vertex count, the overflow flag and all control state.
// a stalled result holds in the output register; commands keep being taken
// until a query finishes while the previous result is still waiting.
`default_nettype none

module point_in_polygon_test_top #(
    parameter int MAX_VERTICES = 256,
    parameter int COORD_BITS   = 32
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cmd_valid,
    output logic                        cmd_ready,
    input  wire pip_pkg::pip_cmd_item_t cmd_data,
    output logic                        res_valid,
    input  wire logic                   res_ready,
    output pip_pkg::pip_res_item_t      res_data
);

    localparam int CB   = COORD_BITS;
    localparam int DW   = CB + 1;
    localparam int PW   = 2 * DW;
    localparam int DB   = pip_pkg::DIGIT_BITS;
    localparam int NDIG = (DW + DB - 1) / DB;
    localparam int BW   = NDIG * DB;
    localparam int AW   = $clog2(MAX_VERTICES);
    localparam int CW   = $clog2(MAX_VERTICES + 1);

    pip_pkg::pip_state_t    state_reg, state_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   ovf_reg, ovf_next;
    logic [CW-1:0]          iss_reg, iss_next;
    logic signed [CB-1:0]   qx_reg, qy_reg, qx_next, qy_next;
    logic                   qovf_reg, qovf_next;
    logic                   par_reg, par_next;
    logic                   res_valid_reg, res_valid_next;
    pip_pkg::pip_res_item_t res_data_reg, res_data_next;

    // read tags, aligned with the memory's registered output
    logic                   rdv_reg, rdf_reg, rdl_reg;
    logic                   rdv_next, rdf_next, rdl_next;
    logic signed [CB-1:0]   prev_x_reg, prev_y_reg;

    logic                   wr_en, rd_en;
    logic [AW-1:0]          rd_addr;
    logic [2*CB-1:0]        wr_data, rd_data;
    logic [CB+31:0]         ext_x, ext_y;
    logic signed [CB-1:0]   in_x, in_y, cur_x, cur_y;

    pip_pkg::pip_tok_t      edge_tok;
    logic [DW-1:0]          e_ma, e_mb, e_mc, e_md;

    pip_pkg::pip_tok_t      tok_w  [NDIG+1];
    logic [DW-1:0]          ma_w   [NDIG+1];
    logic [BW-1:0]          mb_w   [NDIG+1];
    logic [DW-1:0]          mc_w   [NDIG+1];
    logic [BW-1:0]          md_w   [NDIG+1];
    logic [PW-1:0]          acc1_w [NDIG+1];
    logic [PW-1:0]          acc2_w [NDIG+1];

    pip_pkg::pip_tok_t      fin_tok;
    logic                   left;

    // coordinate is the low COORD_BITS bits of the 32-bit field
    assign ext_x   = {{CB{1'b0}}, cmd_data.coord_x};
    assign ext_y   = {{CB{1'b0}}, cmd_data.coord_y};
    assign in_x    = ext_x[CB-1:0];
    assign in_y    = ext_y[CB-1:0];
    assign wr_data = {in_x, in_y};
    assign cur_x   = rd_data[2*CB-1:CB];
    assign cur_y   = rd_data[CB-1:0];

    pip_ram #(
        .WIDTH (2 * CB),
        .DEPTH (MAX_VERTICES)
    ) u_vram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (cnt_reg[AW-1:0]),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        edge_tok      = '0;
        edge_tok.vld  = rdv_reg && !rdf_reg;
        edge_tok.last = rdl_reg;
    end

    // edge i pairs the vertex just read with the one read before it
    pip_edge #(
        .CB (CB),
        .DW (DW)
    ) u_edge (
        .clk    (clk),
        .rst_n  (rst_n),
        .up_tok (edge_tok),
        .xi     (cur_x),
        .yi     (cur_y),
        .xj     (prev_x_reg),
        .yj     (prev_y_reg),
        .px     (qx_reg),
        .py     (qy_reg),
        .dn_tok (tok_w[0]),
        .ma     (e_ma),
        .mb     (e_mb),
        .mc     (e_mc),
        .md     (e_md)
    );

    assign ma_w[0]   = e_ma;
    assign mb_w[0]   = BW'(e_mb);
    assign mc_w[0]   = e_mc;
    assign md_w[0]   = BW'(e_md);
    assign acc1_w[0] = '0;
    assign acc2_w[0] = '0;

    for (genvar k = 0; k < NDIG; k++)
    begin : g_cell
        pip_mac_cell #(
            .DW  (DW),
            .BW  (BW),
            .IDX (k)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .up_tok  (tok_w[k]),
            .up_ma   (ma_w[k]),
            .up_mb   (mb_w[k]),
            .up_mc   (mc_w[k]),
            .up_md   (md_w[k]),
            .up_acc1 (acc1_w[k]),
            .up_acc2 (acc2_w[k]),
            .dn_tok  (tok_w[k+1]),
            .dn_ma   (ma_w[k+1]),
            .dn_mb   (mb_w[k+1]),
            .dn_mc   (mc_w[k+1]),
            .dn_md   (md_w[k+1]),
            .dn_acc1 (acc1_w[k+1]),
            .dn_acc2 (acc2_w[k+1])
        );
    end

    // signed compare of the two products from signs and magnitudes
    always_comb
    begin
        fin_tok = tok_w[NDIG];
        if (fin_tok.n1 != fin_tok.n2)
        begin
            left = fin_tok.n1;
        end
        else if (fin_tok.n1)
        begin
            left = acc1_w[NDIG] > acc2_w[NDIG];
        end
        else
        begin
            left = acc1_w[NDIG] < acc2_w[NDIG];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        ovf_next       = ovf_reg;
        iss_next       = iss_reg;
        qx_next        = qx_reg;
        qy_next        = qy_reg;
        qovf_next      = qovf_reg;
        par_next       = par_reg;
        res_valid_next = res_valid_reg && !res_ready;
        res_data_next  = res_data_reg;
        rdv_next       = 1'b0;
        rdf_next       = 1'b0;
        rdl_next       = 1'b0;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = '0;
        cmd_ready      = 1'b0;

        if (fin_tok.vld && fin_tok.span && left)
        begin
            par_next = !par_reg;
        end

        unique case (state_reg)
            pip_pkg::ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    case (cmd_data.command)
                        pip_pkg::CMD_CLEAR:
                        begin
                            cnt_next = '0;
                            ovf_next = 1'b0;
                        end
                        pip_pkg::CMD_APPEND:
                        begin
                            if (cnt_reg < CW'(MAX_VERTICES))
                            begin
                                wr_en    = 1'b1;
                                cnt_next = cnt_reg + 1'b1;
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        pip_pkg::CMD_QUERY:
                        begin
                            qx_next   = in_x;
                            qy_next   = in_y;
                            qovf_next = ovf_reg;
                            par_next  = 1'b0;
                            iss_next  = '0;
                            state_next = (cnt_reg == '0) ? pip_pkg::ST_DONE
                                                         : pip_pkg::ST_RUN;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            pip_pkg::ST_RUN:
            begin
                // first read fetches the last vertex, then 0 .. n-1
                rd_en    = 1'b1;
                rd_addr  = (iss_reg == '0) ? AW'(cnt_reg - 1'b1)
                                           : AW'(iss_reg - 1'b1);
                rdv_next = 1'b1;
                rdf_next = (iss_reg == '0);
                rdl_next = (iss_reg == cnt_reg);
                iss_next = iss_reg + 1'b1;
                if (iss_reg == cnt_reg)
                begin
                    state_next = pip_pkg::ST_DRAIN;
                end
            end
            pip_pkg::ST_DRAIN:
            begin
                if (fin_tok.vld && fin_tok.last)
                begin
                    state_next = pip_pkg::ST_DONE;
                end
            end
            pip_pkg::ST_DONE:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    res_valid_next          = 1'b1;
                    res_data_next.is_inside = par_reg;
                    res_data_next.overflow  = qovf_reg;
                    state_next              = pip_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pip_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pip_pkg::ST_IDLE;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            iss_reg       <= '0;
            par_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
            rdv_reg       <= 1'b0;
            rdf_reg       <= 1'b0;
            rdl_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            ovf_reg       <= ovf_next;
            iss_reg       <= iss_next;
            par_reg       <= par_next;
            res_valid_reg <= res_valid_next;
            rdv_reg       <= rdv_next;
            rdf_reg       <= rdf_next;
            rdl_reg       <= rdl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qx_reg       <= qx_next;
        qy_reg       <= qy_next;
        qovf_reg     <= qovf_next;
        res_data_reg <= res_data_next;
        if (rdv_reg)
        begin
            prev_x_reg <= cur_x;
            prev_y_reg <= cur_y;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/pip_ram.sv =====
// generic simple dual-port ram with registered read
`default_nettype none

module pip_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/pip_edge.sv =====
// edge front end: span test, differences, operand order and magnitudes
`default_nettype none

module pip_edge #(
    parameter int CB = 32,
    parameter int DW = CB + 1
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire pip_pkg::pip_tok_t      up_tok,
    input  wire logic signed [CB-1:0]   xi,
    input  wire logic signed [CB-1:0]   yi,
    input  wire logic signed [CB-1:0]   xj,
    input  wire logic signed [CB-1:0]   yj,
    input  wire logic signed [CB-1:0]   px,
    input  wire logic signed [CB-1:0]   py,
    output pip_pkg::pip_tok_t           dn_tok,
    output logic [DW-1:0]               ma,
    output logic [DW-1:0]               mb,
    output logic [DW-1:0]               mc,
    output logic [DW-1:0]               md
);

    pip_pkg::pip_tok_t      s1_tok_reg, s1_tok_next;
    logic signed [DW-1:0]   a_reg, b_reg, c_reg, d_reg;
    logic signed [DW-1:0]   a_next, b_next, c_next, d_next;

    pip_pkg::pip_tok_t      s2_tok_reg, s2_tok_next;
    logic [DW-1:0]          ma_reg, mb_reg, mc_reg, md_reg;
    logic [DW-1:0]          ma_next, mb_next, mc_next, md_next;

    logic signed [DW-1:0]   oa, ob, oc, od;
    logic                   dy_pos;

    // stage 1: half-open span in y and the four differences
    always_comb
    begin
        s1_tok_next      = up_tok;
        s1_tok_next.span = ((yi <= py) && (py < yj)) || ((yj <= py) && (py < yi));
        s1_tok_next.n1   = 1'b0;
        s1_tok_next.n2   = 1'b0;
        a_next = {px[CB-1], px} - {xi[CB-1], xi};
        b_next = {yj[CB-1], yj} - {yi[CB-1], yi};
        c_next = {xj[CB-1], xj} - {xi[CB-1], xi};
        d_next = {py[CB-1], py} - {yi[CB-1], yi};
    end

    // stage 2: a*b < c*d, operands swapped when dy is negative
    always_comb
    begin
        dy_pos = !b_reg[DW-1];
        oa = dy_pos ? a_reg : c_reg;
        ob = dy_pos ? b_reg : d_reg;
        oc = dy_pos ? c_reg : a_reg;
        od = dy_pos ? d_reg : b_reg;
        s2_tok_next    = s1_tok_reg;
        s2_tok_next.n1 = (oa != '0) && (ob != '0) && (oa[DW-1] ^ ob[DW-1]);
        s2_tok_next.n2 = (oc != '0) && (od != '0) && (oc[DW-1] ^ od[DW-1]);
        ma_next = oa[DW-1] ? DW'(-oa) : DW'(oa);
        mb_next = ob[DW-1] ? DW'(-ob) : DW'(ob);
        mc_next = oc[DW-1] ? DW'(-oc) : DW'(oc);
        md_next = od[DW-1] ? DW'(-od) : DW'(od);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_tok_reg <= '0;
            s2_tok_reg <= '0;
        end
        else
        begin
            s1_tok_reg <= s1_tok_next;
            s2_tok_reg <= s2_tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg  <= a_next;
        b_reg  <= b_next;
        c_reg  <= c_next;
        d_reg  <= d_next;
        ma_reg <= ma_next;
        mb_reg <= mb_next;
        mc_reg <= mc_next;
        md_reg <= md_next;
    end

    assign dn_tok = s2_tok_reg;
    assign ma     = ma_reg;
    assign mb     = mb_reg;
    assign mc     = mc_reg;
    assign md     = md_reg;

endmodule

`default_nettype wire

// ===== rtl/core/pip_mac_cell.sv =====
// product cell: adds one digit's partial products to both running sums
`default_nettype none

module pip_mac_cell #(
    parameter int DW  = 33,
    parameter int BW  = 48,
    parameter int IDX = 0
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire pip_pkg::pip_tok_t   up_tok,
    input  wire logic [DW-1:0]       up_ma,
    input  wire logic [BW-1:0]       up_mb,
    input  wire logic [DW-1:0]       up_mc,
    input  wire logic [BW-1:0]       up_md,
    input  wire logic [2*DW-1:0]     up_acc1,
    input  wire logic [2*DW-1:0]     up_acc2,
    output pip_pkg::pip_tok_t        dn_tok,
    output logic [DW-1:0]            dn_ma,
    output logic [BW-1:0]            dn_mb,
    output logic [DW-1:0]            dn_mc,
    output logic [BW-1:0]            dn_md,
    output logic [2*DW-1:0]          dn_acc1,
    output logic [2*DW-1:0]          dn_acc2
);

    localparam int DB = pip_pkg::DIGIT_BITS;
    localparam int PW = 2 * DW;
    localparam int SH = IDX * DB;

    pip_pkg::pip_tok_t  tok_reg;
    logic [DW-1:0]      ma_reg, mc_reg;
    logic [BW-1:0]      mb_reg, md_reg;
    logic [PW-1:0]      acc1_reg, acc2_reg;
    logic [PW-1:0]      acc1_next, acc2_next;

    logic [DB-1:0]      dig1, dig2;
    logic [DW+DB-1:0]   p1, p2;

    always_comb
    begin
        dig1 = up_mb[SH +: DB];
        dig2 = up_md[SH +: DB];
        p1   = {{DB{1'b0}}, up_ma} * {{DW{1'b0}}, dig1};
        p2   = {{DB{1'b0}}, up_mc} * {{DW{1'b0}}, dig2};
        // full products fit in PW bits, so truncating a partial one is safe
        acc1_next = up_acc1 + (PW'(p1) << SH);
        acc2_next = up_acc2 + (PW'(p2) << SH);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= up_tok;
        end
    end

    always_ff @(posedge clk)
    begin
        ma_reg   <= up_ma;
        mb_reg   <= up_mb;
        mc_reg   <= up_mc;
        md_reg   <= up_md;
        acc1_reg <= acc1_next;
        acc2_reg <= acc2_next;
    end

    assign dn_tok  = tok_reg;
    assign dn_ma   = ma_reg;
    assign dn_mb   = mb_reg;
    assign dn_mc   = mc_reg;
    assign dn_md   = md_reg;
    assign dn_acc1 = acc1_reg;
    assign dn_acc2 = acc2_reg;

endmodule

`default_nettype wire

// ===== tb/pip_crossing_checker.sv =====
// checker for the point-in-polygon block: tracks the vertex table and scores every result
module pip_crossing_checker #(
    parameter int MAX_VERTICES = 256
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cmd_valid,
    input  wire logic                   cmd_ready,
    input  wire pip_pkg::pip_cmd_item_t cmd_data,
    input  wire logic                   res_valid,
    input  wire logic                   res_ready,
    input  wire pip_pkg::pip_res_item_t res_data,
    output int                          fail_count,
    output int                          pending,
    output int                          result_count,
    output int                          inside_count,
    output int                          overflow_count
);
    timeunit 1ns;
    timeprecision 1ps;

    longint                 vert_x [MAX_VERTICES];
    longint                 vert_y [MAX_VERTICES];
    int                     vert_count;
    logic                   dropped;
    pip_pkg::pip_res_item_t pending_answers[$];
    int                     errors;
    int                     answers;
    int                     insides;
    int                     overflows;

    // even-odd ray cast toward +x, exact integer compare in place of the intersection divide
    function automatic logic crossing_parity(input longint px, input longint py);
        logic               odd;
        logic               left;
        int                 i;
        int                 j;
        logic signed [79:0] dx_pt;
        logic signed [79:0] dy_edge;
        logic signed [79:0] dx_edge;
        logic signed [79:0] dy_pt;
        odd = 1'b0;
        j = vert_count - 1;
        for (i = 0; i < vert_count; i++)
        begin
            // half-open in y, so horizontal edges never qualify
            if ((vert_y[i] <= py && py < vert_y[j]) || (vert_y[j] <= py && py < vert_y[i]))
            begin
                dx_pt   = px - vert_x[i];
                dy_edge = vert_y[j] - vert_y[i];
                dx_edge = vert_x[j] - vert_x[i];
                dy_pt   = py - vert_y[i];
                if (dy_edge > 0)
                    left = (dx_pt * dy_edge) < (dx_edge * dy_pt);
                else
                    left = (dx_edge * dy_pt) < (dx_pt * dy_edge);
                odd ^= left;
            end
            j = i;
        end
        return odd;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pip_pkg::pip_res_item_t want;
        if (!rst_n)
        begin
            vert_count = 0;
            dropped    = 1'b0;
            pending_answers.delete();
            errors     = 0;
            answers    = 0;
            insides    = 0;
            overflows  = 0;
        end
        else
        begin
            // results first: an answer leaving now belongs to an earlier query
            if (res_valid && res_ready)
            begin
                if (pending_answers.size() == 0)
                begin
                    errors++;
                    $error("result with no query waiting: is_inside=%0b overflow=%0b",
                           res_data.is_inside, res_data.overflow);
                end
                else
                begin
                    want = pending_answers.pop_front();
                    answers++;
                    insides   += want.is_inside;
                    overflows += want.overflow;
                    if (res_data.is_inside !== want.is_inside)
                    begin
                        errors++;
                        $error("is_inside: expected %0b, got %0b",
                               want.is_inside, res_data.is_inside);
                    end
                    if (res_data.overflow !== want.overflow)
                    begin
                        errors++;
                        $error("overflow: expected %0b, got %0b",
                               want.overflow, res_data.overflow);
                    end
                end
            end
            if (cmd_valid && cmd_ready)
            begin
                case (cmd_data.command)
                    pip_pkg::CMD_CLEAR:
                    begin
                        vert_count = 0;
                        dropped    = 1'b0;
                    end
                    pip_pkg::CMD_APPEND:
                    begin
                        if (vert_count < MAX_VERTICES)
                        begin
                            vert_x[vert_count] = longint'(cmd_data.coord_x);
                            vert_y[vert_count] = longint'(cmd_data.coord_y);
                            vert_count++;
                        end
                        else
                            dropped = 1'b1;
                    end
                    pip_pkg::CMD_QUERY:
                    begin
                        want.is_inside = crossing_parity(longint'(cmd_data.coord_x),
                                                         longint'(cmd_data.coord_y));
                        want.overflow  = dropped;
                        pending_answers.push_back(want);
                    end
                    default: ;  // unused code changes nothing
                endcase
            end
        end
        fail_count     <= errors;
        pending        <= pending_answers.size();
        result_count   <= answers;
        inside_count   <= insides;
        overflow_count <= overflows;
    end

endmodule

// ===== tb/point_in_polygon_test_top_tb.sv =====
// stimulus and verdict for the point-in-polygon block
module point_in_polygon_test_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int                 NUM_VERTS      = 256;
    localparam logic [1:0]         CMD_UNUSED     = 2'd3;
    localparam int                 ITEM_TARGET    = 1350;
    localparam int                 HOLD_CYCLES    = 400;
    localparam int                 WATCHDOG_LIMIT = 3000;
    localparam int                 SETTLE_CYCLES  = 300;
    localparam logic signed [31:0] C_MIN          = 32'sh8000_0000;
    localparam logic signed [31:0] C_MAX          = 32'sh7fff_ffff;

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   cmd_valid = 1'b0;
    logic                   cmd_ready;
    pip_pkg::pip_cmd_item_t cmd_data  = '0;
    logic                   res_valid;
    logic                   res_ready = 1'b0;
    pip_pkg::pip_res_item_t res_data;

    int   fail_count;
    int   pending;
    int   result_count;
    int   inside_count;
    int   overflow_count;
    int   items_sent = 0;
    logic steady     = 1'b0;
    logic hold_req   = 1'b0;
    logic hold_done  = 1'b0;

    // vertices appended since the last clear, used to aim queries at vertex rows
    logic signed [31:0] poly_x[$];
    logic signed [31:0] poly_y[$];

    point_in_polygon_test_top #(
        .MAX_VERTICES (NUM_VERTS),
        .COORD_BITS   (32)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_data  (cmd_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    pip_crossing_checker #(
        .MAX_VERTICES (NUM_VERTS)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (cmd_valid),
        .cmd_ready      (cmd_ready),
        .cmd_data       (cmd_data),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .res_data       (res_data),
        .fail_count     (fail_count),
        .pending        (pending),
        .result_count   (result_count),
        .inside_count   (inside_count),
        .overflow_count (overflow_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // span 0 means the full coordinate range
    function automatic logic signed [31:0] pick(input int span);
        if (span == 0)
            return $urandom;
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    task automatic send(input logic [1:0] command, input logic signed [31:0] x,
                        input logic signed [31:0] y);
        if (!steady && $urandom_range(0, 99) < 7)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_data  <= '{command: command, coord_x: x, coord_y: y};
        do @(posedge clk); while (!cmd_ready);
        items_sent++;
        if (command == pip_pkg::CMD_CLEAR)
        begin
            poly_x.delete();
            poly_y.delete();
        end
        else if (command == pip_pkg::CMD_APPEND)
        begin
            poly_x.push_back(x);
            poly_y.push_back(y);
        end
    endtask

    task automatic send_query(input int span);
        logic signed [31:0] qx;
        logic signed [31:0] qy;
        int                 k;
        qx = pick(span);
        qy = pick(span);
        if (poly_x.size() > 0)
        begin
            k = $urandom_range(0, poly_x.size() - 1);
            case ($urandom_range(0, 3))
                0: qy = poly_y[k];
                1:
                begin
                    qx = poly_x[k];
                    qy = poly_y[k];
                end
                default: ;
            endcase
        end
        send(pip_pkg::CMD_QUERY, qx, qy);
    endtask

    task automatic build_polygon(input int n, input int span, input bit do_clear);
        if (do_clear)
            send(pip_pkg::CMD_CLEAR, pick(0), pick(0));
        repeat (n) send(pip_pkg::CMD_APPEND, pick(span), pick(span));
    endtask

    // result side: random stalls, plus one long hold-off so the block backs up
    initial
    begin
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                res_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            res_ready <= steady || ($urandom_range(0, 99) >= 7);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((cmd_valid && cmd_ready) || (res_valid && res_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_LIMIT)
            begin
                $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
                $display("FAIL point_in_polygon_test_top");
                $finish;
            end
        end
    end

    initial
    begin
        int phase;
        int n;
        int span;
        int sel;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, one vertex, two vertices
        send(pip_pkg::CMD_QUERY, 0, 0);
        send(pip_pkg::CMD_APPEND, 5, 5);
        send(pip_pkg::CMD_QUERY, 0, 5);
        send(pip_pkg::CMD_APPEND, 5, -5);
        send(pip_pkg::CMD_QUERY, 0, 0);
        // square on the coordinate extremes, two horizontal edges
        send(pip_pkg::CMD_CLEAR, C_MAX, C_MIN);
        send(pip_pkg::CMD_APPEND, C_MIN, C_MIN);
        send(pip_pkg::CMD_APPEND, C_MAX, C_MIN);
        send(pip_pkg::CMD_APPEND, C_MAX, C_MAX);
        send(pip_pkg::CMD_APPEND, C_MIN, C_MAX);
        send(pip_pkg::CMD_QUERY, 0, 0);
        send(pip_pkg::CMD_QUERY, C_MIN, C_MIN);
        send(pip_pkg::CMD_QUERY, C_MAX, 0);
        send(pip_pkg::CMD_QUERY, 0, C_MAX);
        send(CMD_UNUSED, C_MAX, C_MIN);
        send(CMD_UNUSED, -1, -1);
        send(pip_pkg::CMD_QUERY, -1, -1);
        // small triangle, points on vertices and edges
        send(pip_pkg::CMD_CLEAR, -1, 0);
        send(pip_pkg::CMD_APPEND, 0, 0);
        send(pip_pkg::CMD_APPEND, 10, 0);
        send(pip_pkg::CMD_APPEND, 0, 10);
        send(pip_pkg::CMD_QUERY, 3, 3);
        send(pip_pkg::CMD_QUERY, 0, 0);
        send(pip_pkg::CMD_QUERY, -1, 5);
        send(pip_pkg::CMD_QUERY, 5, 5);

        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            steady <= (items_sent >= 500 && items_sent < 800);
            if (!hold_req && items_sent >= 950)
            begin
                hold_req <= 1'b1;
                build_polygon(4, 5000, 1'b1);
                repeat (16) send_query(5000);
            end
            else if ($urandom_range(0, 99) < 8)
                send(2'($urandom_range(0, 3)), pick(0), pick(0));
            else
            begin
                sel  = $urandom_range(0, 9);
                span = (sel < 3) ? 16 : (sel < 7) ? 5000 : 0;
                if (phase == 12)
                    n = NUM_VERTS + 3;
                else if (phase == 40)
                    n = NUM_VERTS;
                else if ($urandom_range(0, 9) == 0)
                    n = $urandom_range(0, 2);
                else
                    n = $urandom_range(3, 12);
                // now and then the clear is left out so the table keeps growing
                build_polygon(n, span, phase == 12 || phase == 40 ||
                              $urandom_range(0, 9) != 0);
                if ($urandom_range(0, 9) == 0)
                    send(CMD_UNUSED, pick(0), pick(0));
                repeat ($urandom_range(1, 6)) send_query(span);
                phase++;
            end
        end
        cmd_valid <= 1'b0;
        steady    <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d commands and %0d query results (%0d inside, %0d flagged overflow)",
                 items_sent, result_count, inside_count, overflow_count);
        $display("with extreme coordinates, short tables, a full table and a long result stall");
        if (fail_count == 0 && pending == 0)
            $display("PASS point_in_polygon_test_top");
        else
            $display("FAIL point_in_polygon_test_top");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/pip_pkg.sv
rtl/core/pip_ram.sv
rtl/core/pip_edge.sv
rtl/core/pip_mac_cell.sv
rtl/core/point_in_polygon_test_top.sv
tb/pip_crossing_checker.sv
tb/point_in_polygon_test_top_tb.sv
